[hdl/uv_sphere_mesh_generator_core_defines.svh]
// Assertion macros shared by the sphere tessellator RTL.
// Depends on nothing; included by the top level.
`ifndef UV_SPHERE_MESH_GENERATOR_CORE_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_CORE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define UVS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvs: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvs: next-cycle check failed");

`endif

[hdl/uvs_pkg.sv]
// Shared types, constants and arithmetic helpers of the sphere tessellator.
// Depends on nothing; used by every module of the block.
package uvs_pkg;

    localparam int MAX_DIVISIONS_DEF = 128;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ARC_LEN           = 24;

    // Long division of the phase dividends: 40 quotient bits, 8 per stage.
    localparam int DIV_BITS   = 40;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // Command codes.
    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_CELL   = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_LAT_DIV = 2'd1;
    localparam logic [1:0] REG_LON_DIV = 2'd2;

    // Side information that travels with an item down the pipeline.
    typedef struct packed {
        logic        is_cell;
        logic        oor;
        logic [14:0] index;
        logic [14:0] index_nxt;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
    } t_tag;

    // Partial long division: remainder and shifting dividend/quotient word.
    typedef struct packed {
        logic [7:0]          rem;
        logic [DIV_BITS-1:0] num;
    } t_div;

    // One CORDIC lane.
    typedef struct packed {
        logic               flip;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] z;
    } t_cord;

    // Output corner slot of a cell item, one-hot.
    typedef enum logic [5:0] {
        CORNER_0 = 6'b000001,
        CORNER_1 = 6'b000010,
        CORNER_2 = 6'b000100,
        CORNER_3 = 6'b001000,
        CORNER_4 = 6'b010000,
        CORNER_5 = 6'b100000
    } t_corner;

    // Arctangent table, 2^32 per turn.
    function automatic logic [31:0] arc_q32(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // DIV_STEPS restoring division steps on a narrow remainder.
    function automatic t_div div_chunk(input t_div a, input logic [7:0] d);
        logic [8:0] r;
        t_div       v;
        v = a;
        for (int k = 0; k < DIV_STEPS; k++) begin
            r = {v.rem, v.num[DIV_BITS-1]};
            v.num = {v.num[DIV_BITS-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                v.num[0] = 1'b1;
            end
            v.rem = r[7:0];
        end
        return v;
    endfunction

    // Fold the phase into the right half plane and set the start vector.
    function automatic t_cord cord_prep(input logic [31:0] phase);
        logic [31:0] q;
        t_cord       v;
        q = phase + 32'h40000000;
        v.flip = q[31];
        v.x    = CORDIC_GAIN;
        v.y    = '0;
        v.z    = $signed({3'b000, q[30:0]}) - 34'sh040000000;
        return v;
    endfunction

    // One rotation step.
    function automatic t_cord cord_iter(input t_cord a, input int i);
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [33:0] at;
        t_cord              v;
        v  = a;
        dx = a.y >>> i;
        dy = a.x >>> i;
        at = $signed({2'b00, arc_q32(i)});
        if (!a.z[33]) begin
            v.x = a.x - dx;
            v.y = a.y + dy;
            v.z = a.z - at;
        end else begin
            v.x = a.x + dx;
            v.y = a.y - dy;
            v.z = a.z + at;
        end
        return v;
    endfunction

endpackage

[hdl/uv_sphere_mesh_generator_core.sv]
// Top level of the UV-sphere tessellator: register port, command intake,
// cell corner sequencing. Depends on uvs_pkg, uvs_div, uvs_cordic, uvs_scale and the defines header.
//
//  Channel    Handshake                     Payload
//  command    start high while busy low     i_cmd, i_lat_index, i_lon_index
//  result     o_valid, one cycle, no hold   o_pos_*, o_norm_*, o_tex_*, o_corner_idx,
//                                           o_last, o_out_of_range
//  registers  psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A command can be taken every cycle while busy is low; its first result passes through
// the intake register, the divider stages, the CORDIC folding, rotation and unfold stages,
// the scaling stages and the output register, with one CORDIC rotation per stage.
// A cell command holds the whole pipeline, and raises busy, while its six corners
// leave. Reset is synchronous and clears valid bits, the corner slot and the registers
// to their defaults; no clearing pass is needed.
module uv_sphere_mesh_generator_core #(
    parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF,
    parameter int CORDIC_STAGES = uvs_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [7:0]         i_lat_index,
    input  logic [7:0]         i_lon_index,
    output logic               o_valid,
    output logic signed [23:0] o_pos_x,
    output logic signed [23:0] o_pos_y,
    output logic signed [23:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic [14:0]        o_corner_idx,
    output logic               o_last,
    output logic               o_out_of_range
);

    `include "uv_sphere_mesh_generator_core_defines.svh"

    localparam logic [7:0] MAX_DIV = (MAX_DIVISIONS > 255) ? 8'd255 : 8'(MAX_DIVISIONS);
    localparam int         DB      = uvs_pkg::DIV_BITS;

    // Configuration registers.
    logic [15:0] r_radius;
    logic [7:0]  r_lat_div;
    logic [7:0]  r_lon_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= 16'd256;
            r_lat_div <= 8'd16;
            r_lon_div <= 8'd32;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                uvs_pkg::REG_RADIUS:  r_radius  <= pwdata[15:0];
                uvs_pkg::REG_LAT_DIV: r_lat_div <= pwdata[7:0];
                uvs_pkg::REG_LON_DIV: r_lon_div <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            uvs_pkg::REG_RADIUS:  prdata = {16'd0, r_radius};
            uvs_pkg::REG_LAT_DIV: prdata = {24'd0, r_lat_div};
            uvs_pkg::REG_LON_DIV: prdata = {24'd0, r_lon_div};
            default:              prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Pipeline control: a cell item at the end holds everything.
    logic             w_en;
    logic             w_stall;
    logic             w_cell_run;
    uvs_pkg::t_corner r_corner;
    logic             f_valid;
    uvs_pkg::t_tag    f_tag;

    assign w_en = !w_stall;
    assign busy = w_stall;

    // Intake: effective divisions, range check, cell indices.
    logic [7:0]    w_ld;
    logic [7:0]    w_od;
    logic          w_cell;
    logic [16:0]   w_cur;
    logic [16:0]   w_nxt;
    uvs_pkg::t_tag w_in_tag;

    always_comb begin
        w_ld = r_lat_div;
        if (r_lat_div == 8'd0) begin
            w_ld = 8'd1;
        end else if (r_lat_div > MAX_DIV) begin
            w_ld = MAX_DIV;
        end
        w_od = r_lon_div;
        if (r_lon_div == 8'd0) begin
            w_od = 8'd1;
        end else if (r_lon_div > MAX_DIV) begin
            w_od = MAX_DIV;
        end
        w_cell = (i_cmd == uvs_pkg::CMD_CELL);
        w_cur  = 17'(i_lat_index) * 17'({1'b0, w_od} + 9'd1) + 17'(i_lon_index);
        w_nxt  = w_cur + 17'(w_od) + 17'd1;
        w_in_tag.is_cell = w_cell;
        if (w_cell) begin
            w_in_tag.oor = (i_lat_index >= w_ld) || (i_lon_index >= w_od);
        end else begin
            w_in_tag.oor = (i_lat_index > w_ld) || (i_lon_index > w_od);
        end
        w_in_tag.index     = w_cur[14:0];
        w_in_tag.index_nxt = w_nxt[14:0];
        w_in_tag.tex_u     = '0;
        w_in_tag.tex_v     = '0;
    end

    logic          r_in_vld;
    uvs_pkg::t_tag r_in_tag;
    logic [DB-1:0] r_in_num_t;
    logic [DB-1:0] r_in_num_p;
    logic [7:0]    r_in_ld;
    logic [7:0]    r_in_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_tag   <= w_in_tag;
            r_in_num_t <= {1'b0, i_lat_index, 31'd0};
            r_in_num_p <= {i_lon_index, 32'd0};
            r_in_ld    <= w_ld;
            r_in_od    <= w_od;
        end
    end

    // Phase division.
    logic          d_valid;
    uvs_pkg::t_tag d_tag;
    logic [DB-1:0] d_qt;
    logic [DB-1:0] d_qp;
    uvs_pkg::t_tag w_c_tag;

    uvs_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_in_vld),
        .i_tag    (r_in_tag),
        .i_num_a  (r_in_num_t),
        .i_den_a  (r_in_ld),
        .i_num_b  (r_in_num_p),
        .i_den_b  (r_in_od),
        .o_valid  (d_valid),
        .o_tag    (d_tag),
        .o_quot_a (d_qt),
        .o_quot_b (d_qp)
    );

    // Texture coordinates are the upper bits of the unreduced phases.
    always_comb begin
        w_c_tag       = d_tag;
        w_c_tag.tex_u = d_qp[32:17];
        w_c_tag.tex_v = d_qt[31:16];
    end

    // Sine and cosine of theta and phi.
    logic               c_valid;
    uvs_pkg::t_tag      c_tag;
    logic signed [31:0] c_ct;
    logic signed [31:0] c_st;
    logic signed [31:0] c_cp;
    logic signed [31:0] c_sp;

    uvs_cordic #(
        .P_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (d_valid),
        .i_tag     (w_c_tag),
        .i_phase_a (d_qt[31:0]),
        .i_phase_b (d_qp[31:0]),
        .o_valid   (c_valid),
        .o_tag     (c_tag),
        .o_cos_a   (c_ct),
        .o_sin_a   (c_st),
        .o_cos_b   (c_cp),
        .o_sin_b   (c_sp)
    );

    // Normal and position.
    logic signed [23:0] f_pos  [3];
    logic signed [15:0] f_norm [3];

    uvs_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (c_valid),
        .i_tag    (c_tag),
        .i_ct     (c_ct),
        .i_st     (c_st),
        .i_cp     (c_cp),
        .i_sp     (c_sp),
        .i_radius (r_radius),
        .o_valid  (f_valid),
        .o_tag    (f_tag),
        .o_pos    (f_pos),
        .o_norm   (f_norm)
    );

    // Cell corner sequencing.
    assign w_cell_run = f_valid && f_tag.is_cell && !f_tag.oor;
    assign w_stall    = w_cell_run && (r_corner != uvs_pkg::CORNER_5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= uvs_pkg::CORNER_0;
        end else if (w_cell_run) begin
            if (r_corner == uvs_pkg::CORNER_5) begin
                r_corner <= uvs_pkg::CORNER_0;
            end else begin
                r_corner <= uvs_pkg::t_corner'({r_corner[4:0], r_corner[5]});
            end
        end
    end

    // Result assembly.
    logic               n_valid;
    logic signed [23:0] n_pos  [3];
    logic signed [15:0] n_norm [3];
    logic [15:0]        n_tex_u;
    logic [15:0]        n_tex_v;
    logic [14:0]        n_index;
    logic               n_last;
    logic               n_oor;

    always_comb begin
        n_valid = f_valid;
        for (int j = 0; j < 3; j++) begin
            n_pos[j]  = '0;
            n_norm[j] = '0;
        end
        n_tex_u = '0;
        n_tex_v = '0;
        n_index = '0;
        n_last  = 1'b1;
        n_oor   = 1'b0;
        if (f_tag.oor) begin
            n_oor = 1'b1;
        end else if (f_tag.is_cell) begin
            n_last = (r_corner == uvs_pkg::CORNER_5);
            unique case (r_corner)
                uvs_pkg::CORNER_0: n_index = f_tag.index;
                uvs_pkg::CORNER_1: n_index = f_tag.index_nxt;
                uvs_pkg::CORNER_2: n_index = f_tag.index + 15'd1;
                uvs_pkg::CORNER_3: n_index = f_tag.index_nxt;
                uvs_pkg::CORNER_4: n_index = f_tag.index_nxt + 15'd1;
                uvs_pkg::CORNER_5: n_index = f_tag.index + 15'd1;
                default:           n_index = '0;
            endcase
        end else begin
            n_pos   = f_pos;
            n_norm  = f_norm;
            n_tex_u = f_tag.tex_u;
            n_tex_v = f_tag.tex_v;
        end
    end

    logic               r_o_valid;
    logic signed [23:0] r_o_pos  [3];
    logic signed [15:0] r_o_norm [3];
    logic [15:0]        r_o_tex_u;
    logic [15:0]        r_o_tex_v;
    logic [14:0]        r_o_index;
    logic               r_o_last;
    logic               r_o_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_pos   <= n_pos;
        r_o_norm  <= n_norm;
        r_o_tex_u <= n_tex_u;
        r_o_tex_v <= n_tex_v;
        r_o_index <= n_index;
        r_o_last  <= n_last;
        r_o_oor   <= n_oor;
    end

    assign o_valid        = r_o_valid;
    assign o_pos_x        = r_o_pos[0];
    assign o_pos_y        = r_o_pos[1];
    assign o_pos_z        = r_o_pos[2];
    assign o_norm_x       = r_o_norm[0];
    assign o_norm_y       = r_o_norm[1];
    assign o_norm_z       = r_o_norm[2];
    assign o_tex_u        = r_o_tex_u;
    assign o_tex_v        = r_o_tex_v;
    assign o_corner_idx   = r_o_index;
    assign o_last         = r_o_last;
    assign o_out_of_range = r_o_oor;

    // A held cell item always produces a result in the next cycle.
    `UVS_ASSERT_NEXT(a_busy_emits, i_clk, i_rst_n, busy, o_valid)
    // The corners of one cell leave back to back.
    `UVS_ASSERT_NEXT(a_cell_gapless, i_clk, i_rst_n, o_valid && !o_last, o_valid)
    // An out-of-range item is a single, final result.
    `UVS_ASSERT_SAME(a_oor_single, i_clk, i_rst_n, o_valid && o_out_of_range, o_last)
    // Corner indices only come with in-range cells.
    `UVS_ASSERT_SAME(a_index_in_range, i_clk, i_rst_n,
        o_valid && (o_corner_idx != 15'd0), !o_out_of_range)

endmodule

[hdl/uvs_div.sv]
// Pipelined long divider for the theta and phi phases, two lanes side by side.
// Depends on uvs_pkg (t_div, t_tag, div_chunk).
module uvs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  uvs_pkg::t_tag               i_tag,
    input  logic [uvs_pkg::DIV_BITS-1:0] i_num_a,
    input  logic [7:0]                  i_den_a,
    input  logic [uvs_pkg::DIV_BITS-1:0] i_num_b,
    input  logic [7:0]                  i_den_b,
    output logic                        o_valid,
    output uvs_pkg::t_tag               o_tag,
    output logic [uvs_pkg::DIV_BITS-1:0] o_quot_a,
    output logic [uvs_pkg::DIV_BITS-1:0] o_quot_b
);

    localparam int NS = uvs_pkg::DIV_STAGES;

    logic [NS-1:0]  r_vld;
    uvs_pkg::t_div  r_a     [NS];
    uvs_pkg::t_div  r_b     [NS];
    logic [7:0]     r_den_a [NS];
    logic [7:0]     r_den_b [NS];
    uvs_pkg::t_tag  r_tag   [NS];

    // Valid bits advance with the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // Each stage resolves DIV_STEPS quotient bits of both lanes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]     <= uvs_pkg::div_chunk(uvs_pkg::t_div'{rem: '0, num: i_num_a}, i_den_a);
            r_b[0]     <= uvs_pkg::div_chunk(uvs_pkg::t_div'{rem: '0, num: i_num_b}, i_den_b);
            r_den_a[0] <= i_den_a;
            r_den_b[0] <= i_den_b;
            r_tag[0]   <= i_tag;
            for (int s = 1; s < NS; s++) begin
                r_a[s]     <= uvs_pkg::div_chunk(r_a[s-1], r_den_a[s-1]);
                r_b[s]     <= uvs_pkg::div_chunk(r_b[s-1], r_den_b[s-1]);
                r_den_a[s] <= r_den_a[s-1];
                r_den_b[s] <= r_den_b[s-1];
                r_tag[s]   <= r_tag[s-1];
            end
        end
    end

    assign o_valid  = r_vld[NS-1];
    assign o_tag    = r_tag[NS-1];
    assign o_quot_a = r_a[NS-1].num;
    assign o_quot_b = r_b[NS-1].num;

endmodule

[hdl/uvs_cordic.sv]
// Two pipelined rotation-mode CORDIC lanes giving cosine and sine in Q2.30.
// Depends on uvs_pkg (t_cord, t_tag, cord_prep, cord_iter).
module uvs_cordic #(
    parameter int P_STAGES = uvs_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  uvs_pkg::t_tag      i_tag,
    input  logic [31:0]        i_phase_a,
    input  logic [31:0]        i_phase_b,
    output logic               o_valid,
    output uvs_pkg::t_tag      o_tag,
    output logic signed [31:0] o_cos_a,
    output logic signed [31:0] o_sin_a,
    output logic signed [31:0] o_cos_b,
    output logic signed [31:0] o_sin_b
);

    localparam int N_ITER = (P_STAGES < uvs_pkg::ARC_LEN) ? P_STAGES : uvs_pkg::ARC_LEN;

    logic [N_ITER+1:0]  r_vld;
    uvs_pkg::t_cord     r_la  [N_ITER+1];
    uvs_pkg::t_cord     r_lb  [N_ITER+1];
    uvs_pkg::t_tag      r_tag [N_ITER+2];
    logic signed [31:0] r_ca;
    logic signed [31:0] r_sa;
    logic signed [31:0] r_cb;
    logic signed [31:0] r_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N_ITER:0], i_valid};
        end
    end

    // Folding stage, one rotation per stage, then undo the half-turn fold.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_la[0]  <= uvs_pkg::cord_prep(i_phase_a);
            r_lb[0]  <= uvs_pkg::cord_prep(i_phase_b);
            r_tag[0] <= i_tag;
            for (int s = 1; s <= N_ITER; s++) begin
                r_la[s]  <= uvs_pkg::cord_iter(r_la[s-1], s - 1);
                r_lb[s]  <= uvs_pkg::cord_iter(r_lb[s-1], s - 1);
                r_tag[s] <= r_tag[s-1];
            end
            r_ca <= r_la[N_ITER].flip ? -r_la[N_ITER].x : r_la[N_ITER].x;
            r_sa <= r_la[N_ITER].flip ? -r_la[N_ITER].y : r_la[N_ITER].y;
            r_cb <= r_lb[N_ITER].flip ? -r_lb[N_ITER].x : r_lb[N_ITER].x;
            r_sb <= r_lb[N_ITER].flip ? -r_lb[N_ITER].y : r_lb[N_ITER].y;
            r_tag[N_ITER+1] <= r_tag[N_ITER];
        end
    end

    assign o_valid = r_vld[N_ITER+1];
    assign o_tag   = r_tag[N_ITER+1];
    assign o_cos_a = r_ca;
    assign o_sin_a = r_sa;
    assign o_cos_b = r_cb;
    assign o_sin_b = r_sb;

endmodule

[hdl/uvs_scale.sv]
// Normal and position arithmetic: products, rounding, radius scaling, clamping.
// Depends on uvs_pkg (t_tag).
module uvs_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  uvs_pkg::t_tag      i_tag,
    input  logic signed [31:0] i_ct,
    input  logic signed [31:0] i_st,
    input  logic signed [31:0] i_cp,
    input  logic signed [31:0] i_sp,
    input  logic [15:0]        i_radius,
    output logic               o_valid,
    output uvs_pkg::t_tag      o_tag,
    output logic signed [23:0] o_pos  [3],
    output logic signed [15:0] o_norm [3]
);

    logic [3:0]         r_vld;
    uvs_pkg::t_tag      r_tag [4];
    logic signed [63:0] r1_mx;
    logic signed [63:0] r1_mz;
    logic signed [31:0] r1_ny;
    logic signed [33:0] r2_n  [3];
    logic signed [50:0] r3_p  [3];
    logic signed [17:0] r3_nn [3];
    logic signed [23:0] r4_pos  [3];
    logic signed [15:0] r4_norm [3];

    logic signed [63:0] w_rx;
    logic signed [63:0] w_rz;
    logic signed [16:0] w_rad;
    logic signed [50:0] w_pr [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // Rounding constants added before the floor shifts.
    always_comb begin
        w_rx  = r1_mx + (64'sd1 <<< 29);
        w_rz  = r1_mz + (64'sd1 <<< 29);
        w_rad = $signed({1'b0, i_radius});
        for (int j = 0; j < 3; j++) begin
            w_pr[j] = (r3_p[j] + (51'sd1 <<< 23)) >>> 24;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage 1: horizontal products.
            r1_mx    <= i_cp * i_st;
            r1_mz    <= i_sp * i_st;
            r1_ny    <= i_ct;
            r_tag[0] <= i_tag;
            // Stage 2: back to Q2.30.
            r2_n[0]  <= 34'(w_rx >>> 30);
            r2_n[1]  <= 34'(r1_ny);
            r2_n[2]  <= 34'(w_rz >>> 30);
            r_tag[1] <= r_tag[0];
            // Stage 3: radius product and Q2.14 rounding.
            for (int j = 0; j < 3; j++) begin
                r3_p[j]  <= 51'(r2_n[j]) * 51'(w_rad);
                r3_nn[j] <= 18'((r2_n[j] + 34'sd32768) >>> 16);
            end
            r_tag[2] <= r_tag[1];
            // Stage 4: clamp to the output ranges.
            for (int j = 0; j < 3; j++) begin
                if (w_pr[j] > 51'sd4194304) begin
                    r4_pos[j] <= 24'sd4194304;
                end else if (w_pr[j] < -51'sd4194304) begin
                    r4_pos[j] <= -24'sd4194304;
                end else begin
                    r4_pos[j] <= w_pr[j][23:0];
                end
                if (r3_nn[j] > 18'sd16384) begin
                    r4_norm[j] <= 16'sd16384;
                end else if (r3_nn[j] < -18'sd16384) begin
                    r4_norm[j] <= -16'sd16384;
                end else begin
                    r4_norm[j] <= r3_nn[j][15:0];
                end
            end
            r_tag[3] <= r_tag[2];
        end
    end

    assign o_valid = r_vld[3];
    assign o_tag   = r_tag[3];
    assign o_pos   = r4_pos;
    assign o_norm  = r4_norm;

endmodule
